[rtl/tbars_pkg.sv]
// shared types, constants and arithmetic helpers for the trackball report splitter
`timescale 1ns / 1ps

package tbars_pkg;

    typedef logic signed [8:0] t_rem;
    typedef logic signed [7:0] t_move;
    typedef logic signed [6:0] t_wheel;
    typedef logic [6:0]        t_chunk;

    localparam t_chunk CHUNK_RESET = 7'd15;
    localparam t_chunk CHUNK_MIN   = 7'd3;
    localparam t_rem   TOTAL_CAP   = 9'sd150;

    // fixed-point 1/10 for the wheel: floor(v * 205 / 2048) == v / 10 for v up to 1028
    localparam logic [16:0] RECIP10     = 17'd205;
    localparam int          RECIP_SHIFT = 11;

    // axis total: sign(net) * min(5^|net|, 150)
    function automatic t_rem axis_total(input t_move neg, input t_move pos);
        logic signed [8:0] net;
        logic [8:0]        mag;
        t_rem              tot;
        net = {pos[7], pos} - {neg[7], neg};
        mag = net[8] ? 9'(-net) : 9'(net);
        case (mag)
            9'd0:    tot = 9'sd0;
            9'd1:    tot = 9'sd5;
            9'd2:    tot = 9'sd25;
            9'd3:    tot = 9'sd125;
            default: tot = TOTAL_CAP;
        endcase
        return net[8] ? -tot : tot;
    endfunction

    // wheel step trunc(3*dy/10), toward zero
    function automatic t_wheel wheel_step(input t_move dy);
        logic [6:0]  mag;
        logic [8:0]  mag3;
        logic [16:0] prod;
        logic [5:0]  quo;
        t_wheel      w;
        mag  = dy[7] ? 7'(-dy) : 7'(dy);
        mag3 = {2'b00, mag} + {1'b0, mag, 1'b0};
        prod = 17'(mag3) * RECIP10;
        quo  = prod[RECIP_SHIFT +: 6];
        w    = $signed({1'b0, quo});
        return dy[7] ? -w : w;
    endfunction

endpackage

[rtl/tbars_if.sv]
// channel interfaces: sample input, report output, chunk size configuration
`timescale 1ns / 1ps

interface tbars_in_if;
    logic              valid;
    logic              ready;
    logic signed [7:0] y_neg_count;
    logic signed [7:0] y_pos_count;
    logic signed [7:0] x_neg_count;
    logic signed [7:0] x_pos_count;
    logic              scroll_mode;

    modport source (output valid, y_neg_count, y_pos_count, x_neg_count, x_pos_count,
                    scroll_mode, input ready);
    modport sink   (input valid, y_neg_count, y_pos_count, x_neg_count, x_pos_count,
                    scroll_mode, output ready);
endinterface

interface tbars_out_if;
    logic              valid;
    logic              ready;
    logic signed [7:0] move_x;
    logic signed [7:0] move_y;
    logic signed [6:0] wheel;
    logic              last;

    modport source (output valid, move_x, move_y, wheel, last, input ready);
    modport sink   (input valid, move_x, move_y, wheel, last, output ready);
endinterface

interface tbars_cfg_if;
    logic       valid;
    logic       ready;
    logic [6:0] chunk_max;

    modport source (output valid, chunk_max, input ready);
    modport sink   (input valid, chunk_max, output ready);
endinterface

[rtl/tbars_chunk_unit.sv]
// shared chunk unit: clamps a remainder to +-chunk and gives the new remainder
`timescale 1ns / 1ps

module tbars_chunk_unit
    import tbars_pkg::*;
(
    input  t_rem   i_rem,
    input  t_chunk i_chunk,
    output t_move  o_part,
    output t_rem   o_rem
);

    t_rem w_pos_c;
    t_rem w_neg_c;

    assign w_pos_c = $signed({2'b00, i_chunk});
    assign w_neg_c = -w_pos_c;

    always_comb begin
        if (i_rem > w_pos_c) begin
            o_part = w_pos_c[7:0];
            o_rem  = i_rem - w_pos_c;
        end else if (i_rem < w_neg_c) begin
            o_part = w_neg_c[7:0];
            o_rem  = i_rem + w_pos_c;
        end else begin
            // remainder fits in one report
            o_part = i_rem[7:0];
            o_rem  = '0;
        end
    end

endmodule

[rtl/trackball_accel_report_splitter_top.sv]
// top level: sample capture, report sequencer, output register, chunk size register
//
//  channel  | dir | handshake     | payload
//  ---------+-----+---------------+------------------------------------------------
//  i_in     | in  | valid / ready | y_neg/y_pos/x_neg/x_pos counts, scroll_mode
//  o_out    | out | valid / ready | move_x, move_y, wheel, last
//  i_cfg    | in  | valid / ready | chunk_max (ready always high)
//
//  a sample is taken while idle; each report then goes through the one chunk unit
//  in an x step and then a y step
//  a sample with no motion gives no report and leaves the sequencer idle
//  the y step waits while the output register holds a report not yet taken
//  input ready is high only while no sample is in progress; synchronous active-low reset
//  sets chunk_max to 15 and empties the output register
`timescale 1ns / 1ps

module trackball_accel_report_splitter_top
    import tbars_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    tbars_in_if.sink      i_in,
    tbars_out_if.source   o_out,
    tbars_cfg_if.sink     i_cfg
);

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_STEP_X = 3'b010,
        S_STEP_Y = 3'b100
    } t_state;

    t_state r_state, n_state;
    t_chunk r_chunk_max;
    t_rem   r_rem_x, n_rem_x;
    t_rem   r_rem_y, n_rem_y;
    t_move  r_dx, n_dx;
    logic   r_scroll, n_scroll;

    logic   r_out_valid, n_out_valid;
    t_move  r_move_x, n_move_x;
    t_move  r_move_y, n_move_y;
    t_wheel r_wheel, n_wheel;
    logic   r_last, n_last;

    t_chunk w_chunk;
    t_rem   w_unit_rem_in;
    t_move  w_unit_part;
    t_rem   w_unit_rem_out;
    logic   w_slot_free;
    logic   w_in_take;
    logic   w_emit;
    logic   w_emit_last;
    t_rem   w_tot_x;
    t_rem   w_tot_y;

    assign w_chunk = (r_chunk_max < CHUNK_MIN) ? CHUNK_MIN : r_chunk_max;

    // one chunk unit shared by both axes
    assign w_unit_rem_in = (r_state == S_STEP_Y) ? r_rem_y : r_rem_x;

    tbars_chunk_unit u_chunk (
        .i_rem   (w_unit_rem_in),
        .i_chunk (w_chunk),
        .o_part  (w_unit_part),
        .o_rem   (w_unit_rem_out)
    );

    assign i_in.ready  = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;
    assign w_in_take   = i_in.valid && i_in.ready;
    assign w_slot_free = !r_out_valid || o_out.ready;
    assign w_emit      = (r_state == S_STEP_Y) && w_slot_free;
    assign w_emit_last = (r_rem_x == '0) && (w_unit_rem_out == '0);

    assign w_tot_x = axis_total(i_in.x_neg_count, i_in.x_pos_count);
    assign w_tot_y = axis_total(i_in.y_neg_count, i_in.y_pos_count);

    always_comb begin
        n_state     = r_state;
        n_rem_x     = r_rem_x;
        n_rem_y     = r_rem_y;
        n_dx        = r_dx;
        n_scroll    = r_scroll;
        n_out_valid = r_out_valid && !o_out.ready;
        n_move_x    = r_move_x;
        n_move_y    = r_move_y;
        n_wheel     = r_wheel;
        n_last      = r_last;

        unique case (r_state)
            S_IDLE: begin
                if (w_in_take) begin
                    n_rem_x  = w_tot_x;
                    n_rem_y  = w_tot_y;
                    n_scroll = i_in.scroll_mode;
                    if (w_tot_x != '0 || w_tot_y != '0) begin
                        n_state = S_STEP_X;
                    end
                end
            end
            S_STEP_X: begin
                n_dx    = w_unit_part;
                n_rem_x = w_unit_rem_out;
                n_state = S_STEP_Y;
            end
            S_STEP_Y: begin
                if (w_emit) begin
                    n_rem_y     = w_unit_rem_out;
                    n_out_valid = 1'b1;
                    n_last      = w_emit_last;
                    if (r_scroll) begin
                        n_move_x = '0;
                        n_move_y = '0;
                        n_wheel  = wheel_step(w_unit_part);
                    end else begin
                        n_move_x = r_dx;
                        n_move_y = w_unit_part;
                        n_wheel  = '0;
                    end
                    n_state = w_emit_last ? S_IDLE : S_STEP_X;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_rem_x     <= '0;
            r_rem_y     <= '0;
            r_chunk_max <= CHUNK_RESET;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_rem_x     <= n_rem_x;
            r_rem_y     <= n_rem_y;
            if (i_cfg.valid && i_cfg.ready) begin
                r_chunk_max <= i_cfg.chunk_max;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_dx     <= n_dx;
        r_scroll <= n_scroll;
        r_move_x <= n_move_x;
        r_move_y <= n_move_y;
        r_wheel  <= n_wheel;
        r_last   <= n_last;
    end

    assign o_out.valid  = r_out_valid;
    assign o_out.move_x = r_move_x;
    assign o_out.move_y = r_move_y;
    assign o_out.wheel  = r_wheel;
    assign o_out.last   = r_last;

    // idle means the previous sample is fully split
    a_idle_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (r_rem_x == '0 && r_rem_y == '0))
        else $error("remainder left over while idle");

    // the final report returns the sequencer to idle
    a_last_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_emit && w_emit_last) |=> (r_state == S_IDLE && r_out_valid && r_last))
        else $error("final report did not end the sample");

    // a wheel report never carries movement
    a_wheel_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_wheel != '0) |-> (r_move_x == '0 && r_move_y == '0))
        else $error("movement alongside wheel step");

    // remainders stay within the acceleration cap
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_rem_x <= TOTAL_CAP && r_rem_x >= -TOTAL_CAP &&
         r_rem_y <= TOTAL_CAP && r_rem_y >= -TOTAL_CAP))
        else $error("remainder beyond cap");

endmodule

[test/tbars_report_checker.sv]
// report checker: predicts mouse reports from accepted samples and compares them
`timescale 1ns / 1ps

module tbars_report_checker
    import tbars_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    tbars_in_if   i_sample,
    tbars_out_if  i_report,
    tbars_cfg_if  i_cfg,
    output int    o_fail_count,
    output int    o_pending
);

    typedef struct packed {
        t_move  move_x;
        t_move  move_y;
        t_wheel wheel;
        logic   last;
    } t_report;

    t_report pending_reports[$];
    t_report oldest;
    t_chunk  chunk_copy = CHUNK_RESET;

    // sign(net) * min(5^|net|, 150), net clamped to +-10
    function automatic int accel_total(input t_move neg, input t_move pos);
        int net;
        int mag;
        int tot;
        net = int'(pos) - int'(neg);
        if (net > 10) net = 10;
        if (net < -10) net = -10;
        mag = (net < 0) ? -net : net;
        tot = (mag == 0) ? 0 : 1;
        for (int i = 0; i < mag; i++) begin
            tot = (tot * 5 > 150) ? 150 : tot * 5;
        end
        return (net < 0) ? -tot : tot;
    endfunction

    // cut one chunk off the remaining axis total
    function automatic int cut_chunk(inout int remaining, input int chunk);
        int part;
        part = remaining;
        if (remaining > chunk) part = chunk;
        else if (remaining < -chunk) part = -chunk;
        if (part == remaining) remaining = 0;
        else if (remaining > 0) remaining = remaining - chunk;
        else remaining = remaining + chunk;
        return part;
    endfunction

    task automatic split_sample();
        int      rem_x;
        int      rem_y;
        int      chunk;
        int      dx;
        int      dy;
        t_report rpt;
        rem_y = accel_total(i_sample.y_neg_count, i_sample.y_pos_count);
        rem_x = accel_total(i_sample.x_neg_count, i_sample.x_pos_count);
        chunk = (chunk_copy < CHUNK_MIN) ? int'(CHUNK_MIN) : int'(chunk_copy);
        while (rem_x != 0 || rem_y != 0) begin
            dx = cut_chunk(rem_x, chunk);
            dy = cut_chunk(rem_y, chunk);
            if (i_sample.scroll_mode) begin
                rpt.move_x = '0;
                rpt.move_y = '0;
                rpt.wheel  = t_wheel'((3 * dy) / 10);
            end else begin
                rpt.move_x = t_move'(dx);
                rpt.move_y = t_move'(dy);
                rpt.wheel  = '0;
            end
            rpt.last = (rem_x == 0 && rem_y == 0);
            pending_reports.push_back(rpt);
        end
    endtask

    task automatic report_mismatch(input string what);
        $display("%0t ns: report mismatch: %s", $time, what);
        o_fail_count++;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            chunk_copy = CHUNK_RESET;
            pending_reports.delete();
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                chunk_copy = i_cfg.chunk_max;
            end
            if (i_report.valid && i_report.ready) begin
                if (pending_reports.size() == 0) begin
                    report_mismatch($sformatf("unexpected report x=%0d y=%0d wheel=%0d last=%0b",
                        i_report.move_x, i_report.move_y, i_report.wheel, i_report.last));
                end else begin
                    oldest = pending_reports.pop_front();
                    if (i_report.move_x !== oldest.move_x)
                        report_mismatch($sformatf("move_x got %0d exp %0d",
                            i_report.move_x, oldest.move_x));
                    if (i_report.move_y !== oldest.move_y)
                        report_mismatch($sformatf("move_y got %0d exp %0d",
                            i_report.move_y, oldest.move_y));
                    if (i_report.wheel !== oldest.wheel)
                        report_mismatch($sformatf("wheel got %0d exp %0d",
                            i_report.wheel, oldest.wheel));
                    if (i_report.last !== oldest.last)
                        report_mismatch($sformatf("last got %0b exp %0b",
                            i_report.last, oldest.last));
                end
            end
            if (i_sample.valid && i_sample.ready) begin
                split_sample();
            end
        end
        o_pending = pending_reports.size();
    end

endmodule

[test/tb_trackball_accel_report_splitter_top.sv]
// testbench top: clock, reset, sample and chunk size stimulus, report stalls, verdict
`timescale 1ns / 1ps

module tb_trackball_accel_report_splitter_top
    import tbars_pkg::*;
();

    logic i_clk;
    logic i_rst_n;
    int   fail_count;
    int   pending;

    tbars_in_if  in_ch ();
    tbars_out_if out_ch ();
    tbars_cfg_if cfg_ch ();

    trackball_accel_report_splitter_top u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    tbars_report_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_sample     (in_ch),
        .i_report     (out_ch),
        .i_cfg        (cfg_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // report receiver: the stall style is picked anew at random whenever its countdown runs out
    int rx_mode  = 0;
    int rx_left  = 0;
    int rx_cycle = 0;

    always @(posedge i_clk) begin
        rx_cycle <= rx_cycle + 1;
        if (rx_left == 0) begin
            rx_mode <= $urandom_range(0, 3);
            rx_left <= $urandom_range(20, 200);
        end else begin
            rx_left <= rx_left - 1;
        end
        case (rx_mode)
            0: out_ch.ready <= 1'b1;
            1: out_ch.ready <= ($urandom_range(0, 3) != 0);
            2: out_ch.ready <= ($urandom_range(0, 2) == 0);
            default: out_ch.ready <= (rx_cycle % 5 == 0);
        endcase
    end

    int burst_left = 0;

    task automatic send_sample(input t_move y_neg, input t_move y_pos,
                               input t_move x_neg, input t_move x_pos, input logic scroll);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 4) == 0) ? $urandom_range(5, 20) : $urandom_range(0, 3);
            burst_left = $urandom_range(1, 16);
            if (gap > 0) begin
                in_ch.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        in_ch.valid       <= 1'b1;
        in_ch.y_neg_count <= y_neg;
        in_ch.y_pos_count <= y_pos;
        in_ch.x_neg_count <= x_neg;
        in_ch.x_pos_count <= x_pos;
        in_ch.scroll_mode <= scroll;
        do @(posedge i_clk); while (!in_ch.ready);
    endtask

    // stop sending, let every predicted report come out, then let the sequencer settle
    task automatic wait_idle();
        in_ch.valid <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_chunk(input t_chunk value);
        cfg_ch.valid     <= 1'b1;
        cfg_ch.chunk_max <= value;
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
    endtask

    initial begin
        t_chunk phase_chunk [6];
        int     moved;
        int     sel;
        int     net_y;
        int     net_x;
        int     base_y;
        int     base_x;
        t_move  yn;
        t_move  yp;
        t_move  xn;
        t_move  xp;
        logic   scroll;

        phase_chunk[0] = 7'd3;
        phase_chunk[1] = 7'd127;
        phase_chunk[2] = 7'd0;
        phase_chunk[3] = 7'd2;
        phase_chunk[4] = t_chunk'($urandom_range(4, 126));
        phase_chunk[5] = t_chunk'($urandom_range(1, 127));

        i_rst_n          <= 1'b0;
        in_ch.valid       <= 1'b0;
        in_ch.y_neg_count <= '0;
        in_ch.y_pos_count <= '0;
        in_ch.x_neg_count <= '0;
        in_ch.x_pos_count <= '0;
        in_ch.scroll_mode <= 1'b0;
        cfg_ch.valid      <= 1'b0;
        cfg_ch.chunk_max  <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed samples at the reset chunk size
        send_sample(8'sd0, 8'sd0, 8'sd0, 8'sd0, 1'b0);
        send_sample(8'sd0, 8'sd1, 8'sd0, 8'sd0, 1'b0);
        send_sample(8'sd1, 8'sd0, 8'sd0, 8'sd0, 1'b0);
        send_sample(8'sd0, 8'sd0, 8'sd0, 8'sd2, 1'b0);
        send_sample(8'sd0, 8'sd0, 8'sd3, 8'sd0, 1'b0);
        send_sample(8'sd0, 8'sd0, 8'sd0, 8'sd4, 1'b0);
        send_sample(8'sd10, 8'sd0, 8'sd0, 8'sd10, 1'b0);
        send_sample(-8'sd128, 8'sd127, 8'sd0, 8'sd0, 1'b0);
        send_sample(8'sd127, -8'sd128, 8'sd0, 8'sd0, 1'b0);
        send_sample(8'sd127, -8'sd128, -8'sd128, 8'sd127, 1'b0);
        send_sample(-8'sd128, -8'sd128, -8'sd128, -8'sd128, 1'b0);
        send_sample(8'sd127, 8'sd127, 8'sd127, 8'sd127, 1'b0);
        send_sample(-8'sd128, -8'sd128, -8'sd127, 8'sd127, 1'b0);
        send_sample(-8'sd4, -8'sd5, 8'sd1, -8'sd2, 1'b0);
        // scroll mode: wheel only, including x-only motion
        send_sample(8'sd0, 8'sd3, 8'sd0, 8'sd0, 1'b1);
        send_sample(8'sd2, 8'sd0, 8'sd0, 8'sd0, 1'b1);
        send_sample(8'sd1, 8'sd0, 8'sd0, 8'sd0, 1'b1);
        send_sample(8'sd0, 8'sd0, 8'sd0, 8'sd4, 1'b1);
        send_sample(8'sd0, 8'sd1, -8'sd128, 8'sd127, 1'b1);
        send_sample(-8'sd128, 8'sd127, 8'sd5, 8'sd5, 1'b1);
        send_sample(8'sd0, 8'sd0, 8'sd0, 8'sd0, 1'b1);
        wait_idle();

        for (int ph = 0; ph < 6; ph++) begin
            write_chunk(phase_chunk[ph]);
            moved = 0;
            while (moved < 58) begin
                sel = $urandom_range(0, 9);
                if (sel < 2) begin
                    // raw bytes, mostly saturated totals
                    yn = t_move'($urandom);
                    yp = t_move'($urandom);
                    xn = t_move'($urandom);
                    xp = t_move'($urandom);
                end else begin
                    net_y  = int'($urandom_range(0, 12)) - 6;
                    net_x  = int'($urandom_range(0, 12)) - 6;
                    if (sel == 2) net_y = 0;
                    if (sel == 3) net_x = 0;
                    base_y = int'($urandom_range(0, 243)) - 122;
                    base_x = int'($urandom_range(0, 243)) - 122;
                    yn = t_move'(base_y);
                    yp = t_move'(base_y + net_y);
                    xn = t_move'(base_x);
                    xp = t_move'(base_x + net_x);
                end
                scroll = ($urandom_range(0, 2) == 0);
                send_sample(yn, yp, xn, xp, scroll);
                if (int'(yp) != int'(yn) || int'(xp) != int'(xn)) moved++;
            end
            wait_idle();
        end

        repeat (20) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("trackball_accel_report_splitter_top regression: pass");
        end else begin
            $display("trackball_accel_report_splitter_top regression: fail");
        end
        $finish;
    end

    initial begin
        #8_000_000;
        $display("trackball_accel_report_splitter_top regression: fail");
        $finish;
    end

endmodule
